// ===== hw/rtl/fra_pkg.sv =====
// Shared types, widths and codes for the fraction arithmetic and reduction unit.
package fra_pkg;

  localparam int unsigned OPERAND_WIDTH = 16;
  localparam int unsigned MUL_W         = OPERAND_WIDTH + 1;
  localparam int unsigned PROD_W        = 2 * MUL_W;
  localparam int unsigned NUM_W         = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned DEN_W         = 2 * OPERAND_WIDTH;
  localparam int unsigned CNT_W         = $clog2(DEN_W);
  localparam int unsigned K_W           = $clog2(DEN_W + 1);
  localparam int unsigned MUL_STEPS     = 3;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  typedef struct packed {
    cmd_t                            cmd;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic        [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic        [OPERAND_WIDTH-1:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] res_num;
    logic        [DEN_W-1:0] res_den;
    logic                    status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_OUT
  } state_t;

endpackage

// ===== hw/rtl/fraction_arith_reduce_unit.sv =====
// Fraction add/sub/mul/div with reduction to lowest terms by binary GCD.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item): one transfer carries an
//   operation code and two fractions, signed numerator over positive
//   denominator. The unit takes one item at a time; in_stall stays high from
//   the transfer until the result has moved into the output register.
//   Output channel (out_valid / out_stall / out_item): one result per item,
//   reduced numerator (sign carrier), positive denominator and a status bit.
//   Division by a zero fraction, or a zero a_den (or b_den for add, sub and
//   mul), gives status 1 with both result fields zero; a zero value comes out as 0/1.
// Sequence: 3 multiply steps on the one 17x17 multiplier, a check state, the
//   binary-GCD loop on the shared 33-bit subtractor, then two 32-bit restoring
//   divisions (numerator, then denominator) on the same subtractor, then the
//   hand-off state; the GCD loop is the variable part. Zero and error results
//   skip GCD and division.
// Stall: the output register holds a finished result while out_stall is high;
//   a following result waits in ST_OUT with in_stall still high, so the next
//   item is not accepted until the held result has moved on.
// Reset: synchronous, active low; clears the sequencer and out_valid.
module fraction_arith_reduce_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fra_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output fra_pkg::out_item_t out_item
);

  localparam int unsigned W = fra_pkg::OPERAND_WIDTH;

  // sequencer and control
  fra_pkg::state_t state_r, state_nxt;
  logic [fra_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  // datapath
  fra_pkg::in_item_t  item_r, item_nxt;
  fra_pkg::out_item_t res_r, res_nxt;
  fra_pkg::out_item_t out_item_r, out_item_nxt;
  logic signed [fra_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [fra_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [fra_pkg::DEN_W-1:0] mag_r, mag_nxt;
  logic                      neg_r, neg_nxt;
  logic [fra_pkg::DEN_W-1:0] x_r, x_nxt;   // GCD operand
  logic [fra_pkg::DEN_W-1:0] y_r, y_nxt;   // GCD operand, then divisor
  logic [fra_pkg::K_W-1:0]   k_r, k_nxt;   // common powers of two
  logic [fra_pkg::DEN_W-1:0] dq_r, dq_nxt; // dividend in, quotient out
  logic [fra_pkg::DEN_W-1:0] rem_r, rem_nxt;

  logic in_xfer, out_free;

  // multiplier operands
  logic signed [fra_pkg::MUL_W-1:0] an_x, bn_x, ad_x, bd_x, an_div, bn_abs;
  logic signed [fra_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [fra_pkg::PROD_W-1:0] prod;
  logic [fra_pkg::NUM_W-1:0] prod_num;
  logic b_neg;

  // shared subtractor
  logic [fra_pkg::DEN_W:0] sub_a, sub_b, sub_d;

  logic [fra_pkg::NUM_W-1:0] num_abs;
  logic [fra_pkg::NUM_W-1:0] mag_ext;
  logic [fra_pkg::DEN_W-1:0] dq_shift;
  logic gcd_equal, div_last, mul_last, div_bit;

  assign in_stall  = (state_r != fra_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------- multiplier ----------------
  assign b_neg  = item_r.b_num[W-1];
  assign an_x   = {item_r.a_num[W-1], item_r.a_num};
  assign bn_x   = {item_r.b_num[W-1], item_r.b_num};
  assign ad_x   = {1'b0, item_r.a_den};
  assign bd_x   = {1'b0, item_r.b_den};
  assign an_div = b_neg ? -an_x : an_x;  // divisor sign moves to the numerator
  assign bn_abs = b_neg ? -bn_x : bn_x;

  always_comb begin
    unique case (cnt_r)
      fra_pkg::CNT_W'(0): begin
        mul_a = (item_r.cmd == fra_pkg::CMD_DIV) ? an_div : an_x;
        mul_b = (item_r.cmd == fra_pkg::CMD_MUL) ? bn_x : bd_x;
      end
      fra_pkg::CNT_W'(1): begin
        mul_a = bn_x;
        mul_b = ad_x;
      end
      default: begin
        mul_a = ad_x;
        mul_b = (item_r.cmd == fra_pkg::CMD_DIV) ? bn_abs : bd_x;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_num = prod[fra_pkg::NUM_W-1:0];
  assign mul_last = (cnt_r == fra_pkg::CNT_W'(fra_pkg::MUL_STEPS - 1));

  // ---------------- shared subtractor ----------------
  always_comb begin
    if (state_r == fra_pkg::ST_GCD) begin
      sub_a = {1'b0, x_r};
    end else begin
      sub_a = {rem_r, dq_r[fra_pkg::DEN_W-1]};
    end
  end
  assign sub_b = {1'b0, y_r};
  assign sub_d = sub_a - sub_b;

  assign gcd_equal = x_r[0] && y_r[0] && (sub_d == '0);
  assign div_bit   = !sub_d[fra_pkg::DEN_W];
  assign div_last  = (cnt_r == fra_pkg::CNT_W'(fra_pkg::DEN_W - 1));
  assign dq_shift  = {dq_r[fra_pkg::DEN_W-2:0], div_bit};

  assign num_abs = num_r[fra_pkg::NUM_W-1] ? -num_r : num_r;
  assign mag_ext = {1'b0, mag_r};

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fra_pkg::ST_IDLE:    if (in_xfer) state_nxt = fra_pkg::ST_MUL;
      fra_pkg::ST_MUL:     if (mul_last) state_nxt = fra_pkg::ST_CHECK;
      fra_pkg::ST_CHECK: begin
        if ((den_r == '0) || (num_r == '0)) begin
          state_nxt = fra_pkg::ST_OUT;
        end else begin
          state_nxt = fra_pkg::ST_GCD;
        end
      end
      fra_pkg::ST_GCD:     if (gcd_equal) state_nxt = fra_pkg::ST_DIV_NUM;
      fra_pkg::ST_DIV_NUM: if (div_last) state_nxt = fra_pkg::ST_DIV_DEN;
      fra_pkg::ST_DIV_DEN: if (div_last) state_nxt = fra_pkg::ST_OUT;
      fra_pkg::ST_OUT:     if (out_free) state_nxt = fra_pkg::ST_IDLE;
      default:             state_nxt = fra_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath / outputs ----------------
  always_comb begin
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      fra_pkg::ST_IDLE: begin
        if (in_xfer) begin
          item_nxt = in_item;
          cnt_nxt  = '0;
        end
      end
      fra_pkg::ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        unique case (cnt_r)
          fra_pkg::CNT_W'(0): num_nxt = prod_num;
          fra_pkg::CNT_W'(1): begin
            if (item_r.cmd == fra_pkg::CMD_ADD) begin
              num_nxt = num_r + prod_num;
            end else if (item_r.cmd == fra_pkg::CMD_SUB) begin
              num_nxt = num_r - prod_num;
            end
          end
          default: den_nxt = prod[fra_pkg::DEN_W-1:0];
        endcase
      end
      fra_pkg::ST_CHECK: begin
        cnt_nxt = '0;
        neg_nxt = num_r[fra_pkg::NUM_W-1];
        mag_nxt = num_abs[fra_pkg::DEN_W-1:0];
        x_nxt   = num_abs[fra_pkg::DEN_W-1:0];
        y_nxt   = den_r;
        k_nxt   = '0;
        if (den_r == '0) begin
          res_nxt.res_num = '0;
          res_nxt.res_den = '0;
          res_nxt.status  = fra_pkg::STATUS_DIV_ZERO;
        end else if (num_r == '0) begin
          res_nxt.res_num = '0;
          res_nxt.res_den = fra_pkg::DEN_W'(1);
          res_nxt.status  = fra_pkg::STATUS_OK;
        end
      end
      fra_pkg::ST_GCD: begin
        // Stein: strip twos, swap so x >= y, then x = (x - y) / 2
        priority if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (gcd_equal) begin
          y_nxt   = x_r << k_r;  // gcd becomes the divisor
          dq_nxt  = mag_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end else if (sub_d[fra_pkg::DEN_W]) begin
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = sub_d[fra_pkg::DEN_W:1];
        end
      end
      fra_pkg::ST_DIV_NUM, fra_pkg::ST_DIV_DEN: begin
        // restoring division, one quotient bit per cycle
        cnt_nxt = cnt_r + 1'b1;
        dq_nxt  = dq_shift;
        rem_nxt = div_bit ? sub_d[fra_pkg::DEN_W-1:0] : sub_a[fra_pkg::DEN_W-1:0];
        if (div_last) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          if (state_r == fra_pkg::ST_DIV_NUM) begin
            mag_nxt = dq_shift;
            dq_nxt  = den_r;
          end else begin
            res_nxt.res_num = neg_r ? -mag_ext : mag_ext;
            res_nxt.res_den = dq_shift;
            res_nxt.status  = fra_pkg::STATUS_OK;
          end
        end
      end
      fra_pkg::ST_OUT: begin
        if (out_free) begin
          out_item_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fra_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    k_r        <= k_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
  end

  // ---------------- assertions ----------------
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fra_pkg::ST_OUT))
    else $error("out_valid rose outside the hand-off state");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fra_pkg::ST_GCD) |-> ((x_r != '0) && (y_r != '0)))
    else $error("GCD operand reached zero");

  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status == fra_pkg::STATUS_OK)) |-> (out_item_r.res_den != '0))
    else $error("good result with zero denominator");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status == fra_pkg::STATUS_DIV_ZERO))
      |-> ((out_item_r.res_num == '0) && (out_item_r.res_den == '0)))
    else $error("error result with nonzero fields");

endmodule

// ===== tb/fraction_arith_reduce_unit_test.sv =====
// Self-checking testbench for the fraction arithmetic and reduction unit.
`timescale 1ns / 1ps

module fraction_arith_reduce_unit_test;

  // Longest run of cycles with no transfer on either channel before we give up.
  // This is many times the worst honest stretch: one item's processing plus
  // a long sender gap or receiver stall.
  localparam int QUIET_LIMIT   = 5000;
  // Cycles to wait after the last result for anything stray to come out.
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    fra_pkg::in_item_t  item;
    bit                 known;   // result typed in by hand, else from the predictor
    fra_pkg::out_item_t res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fra_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fra_pkg::out_item_t out_item;

  // Expected results, oldest first, pushed when the input transfer happens.
  fra_pkg::out_item_t predicted_fractions[$];
  stim_row_t directed_rows[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;   // cleared for stretches with back-to-back traffic

  fraction_arith_reduce_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Cross products, then reduction to lowest terms on magnitudes; the sign
  // rides on the numerator. Zero denominators (an input one, but for b's in a
  // divide, or a zero divisor fraction) give the error status with both fields zero.
  function automatic fra_pkg::out_item_t reduce_fraction(fra_pkg::in_item_t it);
    longint             an, ad, bn, bd, num, den, sn;
    longint unsigned    mag, x, y, r, rd;
    fra_pkg::out_item_t res;
    an = $signed(it.a_num);
    ad = it.a_den;
    bn = $signed(it.b_num);
    bd = it.b_den;
    case (it.cmd)
      fra_pkg::CMD_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      fra_pkg::CMD_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      fra_pkg::CMD_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      default: begin
        // divide: multiply by the reciprocal, moving a negative sign up top
        num = an * bd;
        den = ad * bn;
        if (bn < 0) begin
          num = -num;
          den = -den;
        end
      end
    endcase
    res = '0;
    if (den <= 0) begin
      res.status = fra_pkg::STATUS_DIV_ZERO;
    end else if (num == 0) begin
      res.res_den = fra_pkg::DEN_W'(1);
      res.status  = fra_pkg::STATUS_OK;
    end else begin
      mag = (num < 0) ? -num : num;
      x = mag;
      y = den;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      mag = mag / x;
      rd  = den;
      rd  = rd / x;
      sn  = mag;
      if (num < 0) sn = -sn;
      res.res_num = sn[fra_pkg::NUM_W-1:0];
      res.res_den = rd[fra_pkg::DEN_W-1:0];
      res.status  = fra_pkg::STATUS_OK;
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none while idling is off.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 20);
    return $urandom_range(50, 200);
  endfunction

  // Numerators: full-width noise, small values that share factors, extremes, signed powers of two.
  function automatic logic [fra_pkg::OPERAND_WIDTH-1:0] rand_numerator();
    logic [fra_pkg::OPERAND_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = fra_pkg::OPERAND_WIDTH'($urandom);
      4, 5, 6, 7: v = fra_pkg::OPERAND_WIDTH'($urandom_range(0, 48) - 24);
      8: begin
        case ($urandom_range(0, 4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          3: v = 16'h0000;
          default: v = 16'h0001;
        endcase
      end
      default: begin
        v = 16'h0001 << $urandom_range(0, fra_pkg::OPERAND_WIDTH - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Denominators: mostly in range; a zero now and then to hit the error path.
  function automatic logic [fra_pkg::OPERAND_WIDTH-1:0] rand_denominator();
    logic [fra_pkg::OPERAND_WIDTH-1:0] v;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: v = fra_pkg::OPERAND_WIDTH'($urandom);
      8, 9, 10, 11, 12, 13, 14, 15: v = fra_pkg::OPERAND_WIDTH'($urandom_range(1, 24));
      16, 17: begin
        case ($urandom_range(0, 3))
          0: v = 16'h0001;
          1: v = 16'hffff;
          2: v = 16'hfffe;
          default: v = 16'h8000;
        endcase
      end
      18: v = fra_pkg::OPERAND_WIDTH'(12 * $urandom_range(1, 5000));
      default: v = ($urandom_range(0, 3) == 0) ? 16'h0000 :
                   fra_pkg::OPERAND_WIDTH'($urandom_range(1, 6));
    endcase
    return v;
  endfunction

  function automatic fra_pkg::in_item_t rand_fraction_item();
    fra_pkg::in_item_t it;
    it.cmd   = fra_pkg::cmd_t'($urandom_range(0, 3));
    it.a_num = rand_numerator();
    it.a_den = rand_denominator();
    it.b_num = rand_numerator();
    it.b_den = rand_denominator();
    return it;
  endfunction

  task automatic add_row(input fra_pkg::cmd_t c, input int an, input int ad, input int bn,
                         input int bd, input bit known, input longint rn,
                         input longint rd, input logic st);
    stim_row_t row;
    row.item.cmd   = c;
    row.item.a_num = fra_pkg::OPERAND_WIDTH'(an);
    row.item.a_den = fra_pkg::OPERAND_WIDTH'(ad);
    row.item.b_num = fra_pkg::OPERAND_WIDTH'(bn);
    row.item.b_den = fra_pkg::OPERAND_WIDTH'(bd);
    row.known       = known;
    row.res.res_num = rn[fra_pkg::NUM_W-1:0];
    row.res.res_den = rd[fra_pkg::DEN_W-1:0];
    row.res.status  = st;
    directed_rows.push_back(row);
  endtask

  // One input transfer. Valid goes up at a falling edge after the gap and
  // stays put until the unit drops in_stall; with no gap the next item
  // replaces the last one without valid dipping.
  task automatic send_fraction(input fra_pkg::in_item_t it, input fra_pkg::out_item_t exp_res);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted_fractions.push_back(exp_res);
  endtask

  // Receiver back-pressure: random stall bursts, changed on falling edges.
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk) begin
    fra_pkg::out_item_t exp_res;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (predicted_fractions.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result %0d/%0d status %0b", out_item.res_num,
                   out_item.res_den, out_item.status);
      end else begin
        exp_res = predicted_fractions.pop_front();
        if (out_item.res_num !== exp_res.res_num || out_item.res_den !== exp_res.res_den ||
            out_item.status !== exp_res.status) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch: expected %0d/%0d status %0b, got %0d/%0d status %0b",
                     exp_res.res_num, exp_res.res_den, exp_res.status,
                     out_item.res_num, out_item.res_den, out_item.status);
        end
      end
    end
  end

  // Watchdog: counts cycles without a transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    fra_pkg::in_item_t it;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: cmd, a, b, and the answer where it is obvious.
    add_row(fra_pkg::CMD_ADD,      1,     2,      1,     3, 1,      5,     6,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_SUB,      1,     2,      1,     2, 1,      0,     1,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_MUL,      2,     3,      3,     4, 1,      1,     2,
            fra_pkg::STATUS_OK);
    // zero divisor fraction
    add_row(fra_pkg::CMD_DIV,      1,     2,      0,     5, 1,      0,     0,
            fra_pkg::STATUS_DIV_ZERO);
    add_row(fra_pkg::CMD_DIV,      0,     1,      0,     1, 1,      0,     0,
            fra_pkg::STATUS_DIV_ZERO);
    // negative divisor: its sign lands on the numerator
    add_row(fra_pkg::CMD_DIV,      1,     2,     -1,     3, 1,     -3,     2,
            fra_pkg::STATUS_OK);
    // zero input denominators
    add_row(fra_pkg::CMD_ADD,      3,     0,      1,     5, 1,      0,     0,
            fra_pkg::STATUS_DIV_ZERO);
    add_row(fra_pkg::CMD_MUL,      3,     7,      1,     0, 1,      0,     0,
            fra_pkg::STATUS_DIV_ZERO);
    add_row(fra_pkg::CMD_DIV,      3,     0,     -2,     5, 1,      0,     0,
            fra_pkg::STATUS_DIV_ZERO);
    add_row(fra_pkg::CMD_DIV,      3,     7,      2,     0, 0,      0,     0,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_SUB,      4,     9,      4,     0, 0,      0,     0,
            fra_pkg::STATUS_OK);
    // numerator and denominator extremes
    add_row(fra_pkg::CMD_ADD, -32768,     1, -32768,     1, 1, -65536,     1,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_MUL, -32768,     1, -32768,     1, 1, 1073741824, 1,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_DIV, -32768,     1, -32768,     1, 1,      1,     1,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_SUB,  32767,     1, -32768,     1, 1,  65535,     1,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_MUL,     -1, 65535,      1, 65535, 1,     -1, 4294836225,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_MUL,      0,     7,      5,     3, 1,      0,     1,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_ADD,  32767, 65535,  32767, 65535, 0,      0,     0,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_SUB, -32768, 65535,  32767,     1, 0,      0,     0,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_DIV,  32767, 65535, -32768, 65535, 0,      0,     0,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_ADD,      1, 65535,      1, 65534, 0,      0,     0,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_ADD, -32768, 65535, -32768, 65534, 0,      0,     0,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_DIV, -32768, 65535,      1, 65535, 0,      0,     0,
            fra_pkg::STATUS_OK);
    add_row(fra_pkg::CMD_SUB,  32767, 65535, -32768, 65534, 0,      0,     0,
            fra_pkg::STATUS_OK);

    foreach (directed_rows[i])
      send_fraction(directed_rows[i].item, directed_rows[i].known ?
                    directed_rows[i].res : reduce_fraction(directed_rows[i].item));

    // Random part; every fourth block of 200 runs with no gaps or stalls.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = ((n / 200) % 4) != 3;
      it = rand_fraction_item();
      send_fraction(it, reduce_fraction(it));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    idle_on = 1'b0;

    // Drain; the watchdog catches a result that never shows up.
    while (predicted_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && predicted_fractions.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
